// ===== hw/rtl/wck_pkg.sv =====
// Shared types and constants for the wheel chassis kinematics block.
// Used by every module under hw/rtl; depends on nothing else.
`default_nettype none

package wck_pkg;

    // Result, divider dividend, operand and coefficient widths.
    localparam int OUT_W  = 32;
    localparam int DIV_W  = 38;
    localparam int OPND_W = 43;
    localparam int COEF_W = 20;

    // Fixed-point constants: sin(60deg) and 30/pi in Q.16, pi/(30*sqrt3) and pi/90 in Q0.24.
    localparam logic [16:0]       SIN60_Q16  = 17'd56756;
    localparam logic [COEF_W-1:0] K30PI_Q16  = 20'd625823;
    localparam logic [COEF_W-1:0] C_VX_Q24   = 20'd1014350;
    localparam logic [COEF_W-1:0] C_PI90_Q24 = 20'd585635;

    // Chassis mode codes as written to the mode register.
    localparam logic [2:0] MODE_CODE_DIFF = 3'd2;
    localparam logic [2:0] MODE_CODE_OMNI = 3'd3;

    // Register reset values.
    localparam logic [2:0]  RST_MODE    = MODE_CODE_DIFF;
    localparam logic [15:0] RST_RADIUS  = 16'd3277;
    localparam logic [15:0] RST_SPACING = 16'd13107;
    localparam logic [14:0] RST_LIM_LIN = 15'd2048;
    localparam logic [14:0] RST_LIM_ANG = 15'd4096;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_MODE    = 3'd0,
        REG_RADIUS  = 3'd1,
        REG_SPACING = 3'd2,
        REG_LIM_LIN = 3'd3,
        REG_LIM_ANG = 3'd4
    } t_reg_idx;

    // Decoded chassis class.
    typedef enum logic [1:0] {
        CLS_DIFF,
        CLS_OMNI,
        CLS_NONE
    } t_cls;

    // How a lane finishes its result.
    typedef enum logic [1:0] {
        KIND_BYP,
        KIND_SHR,
        KIND_DIV
    } t_kind;

    // Per-lane command from the front end to the scaling stages.
    typedef struct packed {
        t_kind                     kind;
        logic                      fwd;
        logic [15:0]               d;
        logic signed [OPND_W-1:0]  opnd;
        logic [COEF_W-1:0]         coef;
        logic signed [OUT_W-1:0]   byp;
    } t_lane_cmd;

    // Side information that rides along the divider.
    typedef struct packed {
        logic                    use_div;
        logic                    neg;
        logic signed [OUT_W-1:0] byp;
    } t_side;

endpackage

`default_nettype wire

// ===== hw/rtl/wck_front.sv =====
// Front end: command clamping, first products and per-lane operand selection.
// Three register stages; depends on wck_pkg.
`default_nettype none

module wck_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire logic                 i_action,
    input  wire logic signed [15:0]   i_lin_x,
    input  wire logic signed [15:0]   i_lin_y,
    input  wire logic signed [15:0]   i_ang_z,
    input  wire logic signed [23:0]   i_wheel_a,
    input  wire logic signed [23:0]   i_wheel_b,
    input  wire logic signed [23:0]   i_wheel_c,
    input  wire logic [2:0]           i_mode,
    input  wire logic [15:0]          i_radius,
    input  wire logic [15:0]          i_spacing,
    input  wire logic [14:0]          i_lim_lin,
    input  wire logic [14:0]          i_lim_ang,
    output wck_pkg::t_lane_cmd        o_cmd_a,
    output wck_pkg::t_lane_cmd        o_cmd_b,
    output wck_pkg::t_lane_cmd        o_cmd_c
);
    import wck_pkg::*;

    // Stage 1 registers.
    logic               r1_act;
    t_cls               r1_cls;
    logic [15:0]        r1_r, r1_s;
    logic signed [15:0] r1_x, r1_y, r1_w;
    logic signed [24:0] r1_dab, r1_sab;
    logic signed [25:0] r1_s2, r1_s3;

    // Stage 2 registers.
    logic               r2_act;
    t_cls               r2_cls;
    logic [15:0]        r2_r, r2_s;
    logic signed [15:0] r2_x, r2_y;
    logic signed [24:0] r2_dab, r2_sab;
    logic signed [32:0] r2_xs, r2_sw;
    logic signed [41:0] r2_p1;
    logic signed [42:0] r2_p2, r2_p3;

    // Stage 1 combinational values.
    logic signed [15:0] n_x, n_w, lim_l, lim_a;
    t_cls               n_cls;
    logic signed [24:0] ea, eb;
    logic signed [25:0] fa, fb, fc;

    // Stage 3 combinational values.
    logic signed [34:0] xs_e, sw_e, yh_e, yf_e, na, nb, nc;
    logic               h_neg;
    logic [32:0]        h_mag;
    logic [32:0]        h_sum;
    logic signed [17:0] h_val;
    logic signed [18:0] d_ra, d_rb;
    t_lane_cmd          n_cmd_a, n_cmd_b, n_cmd_c;

    // Clamp the x linear and angular commands, decode the mode, sign-extend the wheel inputs.
    always_comb begin
        lim_l = $signed({1'b0, i_lim_lin});
        lim_a = $signed({1'b0, i_lim_ang});
        if (i_lin_x > lim_l) begin
            n_x = lim_l;
        end else if (i_lin_x < -lim_l) begin
            n_x = -lim_l;
        end else begin
            n_x = i_lin_x;
        end
        if (i_ang_z > lim_a) begin
            n_w = lim_a;
        end else if (i_ang_z < -lim_a) begin
            n_w = -lim_a;
        end else begin
            n_w = i_ang_z;
        end
        if (i_mode == MODE_CODE_DIFF) begin
            n_cls = CLS_DIFF;
        end else if (i_mode == MODE_CODE_OMNI) begin
            n_cls = CLS_OMNI;
        end else begin
            n_cls = CLS_NONE;
        end
        ea = {i_wheel_a[23], i_wheel_a};
        eb = {i_wheel_b[23], i_wheel_b};
        fa = {{2{i_wheel_a[23]}}, i_wheel_a};
        fb = {{2{i_wheel_b[23]}}, i_wheel_b};
        fc = {{2{i_wheel_c[23]}}, i_wheel_c};
    end

    // Stage 1: register clamped commands and wheel sums.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_act <= i_action;
            r1_cls <= n_cls;
            r1_r   <= (i_radius == 16'd0) ? 16'd1 : i_radius;
            r1_s   <= (i_spacing == 16'd0) ? 16'd1 : i_spacing;
            r1_x   <= n_x;
            r1_y   <= i_lin_y;
            r1_w   <= n_w;
            r1_dab <= ea - eb;
            r1_sab <= ea + eb;
            r1_s2  <= fa + fb - (fc <<< 1);
            r1_s3  <= fa + fb + fc;
        end
    end

    // Stage 2: first products.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_act <= r1_act;
            r2_cls <= r1_cls;
            r2_r   <= r1_r;
            r2_s   <= r1_s;
            r2_x   <= r1_x;
            r2_y   <= r1_y;
            r2_dab <= r1_dab;
            r2_sab <= r1_sab;
            r2_xs  <= r1_x * $signed(SIN60_Q16);
            r2_sw  <= $signed({1'b0, r1_s}) * r1_w;
            r2_p1  <= r1_dab * $signed({1'b0, r1_r});
            r2_p2  <= r1_s2 * $signed({1'b0, r1_r});
            r2_p3  <= r1_s3 * $signed({1'b0, r1_r});
        end
    end

    // Omni numerators and the differential half-spacing term.
    always_comb begin
        xs_e  = {{2{r2_xs[32]}}, r2_xs};
        sw_e  = {{2{r2_sw[32]}}, r2_sw};
        yh_e  = {{4{r2_y[15]}}, r2_y, 15'd0};
        yf_e  = {{3{r2_y[15]}}, r2_y, 16'd0};
        na    = xs_e + yh_e + sw_e;
        nb    = yh_e + sw_e - xs_e;
        nc    = sw_e - yf_e;
        h_neg = r2_sw[32];
        h_mag = h_neg ? 33'(-r2_sw) : 33'(r2_sw);
        h_sum = h_mag + 33'd65536;
        h_val = h_neg ? -$signed({2'b00, h_sum[32:17]}) : $signed({2'b00, h_sum[32:17]});
        d_ra  = {{3{r2_x[15]}}, r2_x} - {h_val[17], h_val};
        d_rb  = -({{3{r2_x[15]}}, r2_x} + {h_val[17], h_val});
    end

    // Lane command selection by action and chassis class.
    always_comb begin
        n_cmd_a = '{kind: KIND_BYP, fwd: 1'b0, d: r2_r, opnd: '0, coef: '0, byp: '0};
        n_cmd_b = n_cmd_a;
        n_cmd_c = n_cmd_a;
        case (r2_cls)
            CLS_DIFF: begin
                if (r2_act) begin
                    n_cmd_a.byp = OUT_W'(-r2_dab);
                    n_cmd_b.byp = OUT_W'(r2_sab);
                end else begin
                    n_cmd_a.byp = OUT_W'(d_ra);
                    n_cmd_b.byp = OUT_W'(d_rb);
                end
            end
            CLS_OMNI: begin
                if (r2_act) begin
                    n_cmd_a.kind = KIND_SHR;
                    n_cmd_a.opnd = OPND_W'(r2_p1);
                    n_cmd_a.coef = C_VX_Q24;
                    n_cmd_b.kind = KIND_SHR;
                    n_cmd_b.opnd = r2_p2;
                    n_cmd_b.coef = C_PI90_Q24;
                    n_cmd_c.kind = KIND_DIV;
                    n_cmd_c.fwd  = 1'b1;
                    n_cmd_c.d    = r2_s;
                    n_cmd_c.opnd = r2_p3;
                    n_cmd_c.coef = C_PI90_Q24;
                end else begin
                    n_cmd_a.kind = KIND_DIV;
                    n_cmd_a.opnd = OPND_W'(na);
                    n_cmd_a.coef = K30PI_Q16;
                    n_cmd_b.kind = KIND_DIV;
                    n_cmd_b.opnd = OPND_W'(nb);
                    n_cmd_b.coef = K30PI_Q16;
                    n_cmd_c.kind = KIND_DIV;
                    n_cmd_c.opnd = OPND_W'(nc);
                    n_cmd_c.coef = K30PI_Q16;
                end
            end
            default: begin
            end
        endcase
    end

    // Stage 3: lane commands.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_cmd_a <= n_cmd_a;
            o_cmd_b <= n_cmd_b;
            o_cmd_c <= n_cmd_c;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/wck_scale.sv =====
// Scaling lane: constant multiply, magnitude and rounding into a divider dividend.
// Three register stages; depends on wck_pkg.
`default_nettype none

module wck_scale (
    input  wire logic                   i_clk,
    input  wire logic                   i_en,
    input  wck_pkg::t_lane_cmd          i_cmd,
    output logic [wck_pkg::DIV_W-1:0]   o_dividend,
    output logic [15:0]                 o_d,
    output wck_pkg::t_side              o_side
);
    import wck_pkg::*;

    // Stage 4 registers.
    t_kind                    r4_kind;
    logic                     r4_fwd;
    logic [15:0]              r4_d;
    logic signed [OUT_W-1:0]  r4_byp;
    logic signed [63:0]       r4_prod;

    // Stage 5 registers.
    t_kind                    r5_kind;
    logic                     r5_fwd;
    logic [15:0]              r5_d;
    logic signed [OUT_W-1:0]  r5_byp;
    logic                     r5_neg;
    logic [62:0]              r5_mag;

    // Stage 6 combinational values.
    logic [62:0]              n_add;
    logic [62:0]              n_sum;
    logic [62:0]              n_shr;
    logic signed [OUT_W-1:0]  n_q;
    t_side                    n_side;
    logic [DIV_W-1:0]         n_dividend;

    // Stage 4: constant multiply.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_kind <= i_cmd.kind;
            r4_fwd  <= i_cmd.fwd;
            r4_d    <= i_cmd.d;
            r4_byp  <= i_cmd.byp;
            r4_prod <= i_cmd.opnd * $signed({1'b0, i_cmd.coef});
        end
    end

    // Stage 5: sign and magnitude.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_kind <= r4_kind;
            r5_fwd  <= r4_fwd;
            r5_d    <= r4_d;
            r5_byp  <= r4_byp;
            r5_neg  <= r4_prod[63];
            r5_mag  <= r4_prod[63] ? 63'(-r4_prod) : r4_prod[62:0];
        end
    end

    // Round-half-away bias, then either a power-of-two shift or a divider dividend.
    always_comb begin
        n_add      = r5_fwd ? {24'd0, r5_d, 23'd0} : {32'd0, r5_d, 15'd0};
        n_sum      = r5_mag + n_add;
        n_dividend = r5_fwd ? n_sum[24 +: DIV_W] : n_sum[16 +: DIV_W];
        n_shr      = r5_mag + {23'd0, 1'b1, 39'd0};
        n_q        = $signed({9'd0, n_shr[62:40]});
        n_side     = '{use_div: 1'b0, neg: r5_neg, byp: r5_byp};
        case (r5_kind)
            KIND_SHR: n_side.byp = r5_neg ? -n_q : n_q;
            KIND_DIV: n_side.use_div = 1'b1;
            default:  n_side.use_div = 1'b0;
        endcase
    end

    // Stage 6: divider operands.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_dividend <= n_dividend;
            o_d        <= r5_d;
            o_side     <= n_side;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/wck_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, 16-bit divisor.
// Depends on wck_pkg for the side-data type.
`default_nettype none

module wck_div #(
    parameter int DIV_W = wck_pkg::DIV_W
) (
    input  wire logic                i_clk,
    input  wire logic                i_en,
    input  wire logic [DIV_W-1:0]    i_dividend,
    input  wire logic [15:0]         i_d,
    input  wck_pkg::t_side           i_side,
    output logic [DIV_W-1:0]         o_q,
    output wck_pkg::t_side           o_side
);
    import wck_pkg::*;

    // Per-stage registers: dividend bits still to shift in, with quotient bits below them.
    logic [DIV_W-1:0] r_nq   [DIV_W];
    logic [15:0]      r_rem  [DIV_W];
    logic [15:0]      r_d    [DIV_W];
    t_side            r_side [DIV_W];

    for (genvar k = 0; k < DIV_W; k++) begin : g_stage
        logic [DIV_W-1:0] nq_in;
        logic [15:0]      rem_in;
        logic [15:0]      d_in;
        t_side            side_in;
        logic [16:0]      trial;
        logic             ge;

        if (k == 0) begin : g_first
            assign nq_in   = i_dividend;
            assign rem_in  = '0;
            assign d_in    = i_d;
            assign side_in = i_side;
        end else begin : g_next
            assign nq_in   = r_nq[k-1];
            assign rem_in  = r_rem[k-1];
            assign d_in    = r_d[k-1];
            assign side_in = r_side[k-1];
        end

        // Shift in the next dividend bit and try to subtract the divisor.
        assign trial = {rem_in, nq_in[DIV_W-1]};
        assign ge    = (trial >= {1'b0, d_in});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_nq[k]   <= {nq_in[DIV_W-2:0], ge};
                r_rem[k]  <= ge ? 16'(trial - {1'b0, d_in}) : trial[15:0];
                r_d[k]    <= d_in;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_q    = r_nq[DIV_W-1];
    assign o_side = r_side[DIV_W-1];

endmodule

`default_nettype wire

// ===== hw/rtl/wheel_chassis_kinematics.sv =====
// Top level of the wheel chassis kinematics block: registers, pipeline and output stage.
// Depends on wck_pkg, wck_front, wck_scale and wck_div.
//
//   Channel  Direction  Handshake                   Payload
//   in       sink       i_in_valid / o_in_ready     i_action, i_lin_*, i_ang_z, i_wheel_*
//   out      source     o_out_valid / i_out_ready   o_out_a/b/c, o_mode_unsupported
//   cfg      sink       i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// One item is taken per cycle while the pipeline is not stalled; results pass through the front
// end, the scaling lanes, the one-bit-per-stage divider (38-bit by default) and the output register.
// The whole pipeline advances as one when the output register is empty or
// being drained, so a stall holds every stage in place.
// Reset is synchronous and active low; it clears the valid bits and loads the
// register defaults. Configuration transfers are always accepted.
`default_nettype none

module wheel_chassis_kinematics (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic                  i_action,
    input  wire logic signed [15:0]    i_lin_x,
    input  wire logic signed [15:0]    i_lin_y,
    input  wire logic signed [15:0]    i_ang_z,
    input  wire logic signed [23:0]    i_wheel_a,
    input  wire logic signed [23:0]    i_wheel_b,
    input  wire logic signed [23:0]    i_wheel_c,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic signed [31:0]         o_out_a,
    output logic signed [31:0]         o_out_b,
    output logic signed [31:0]         o_out_c,
    output logic                       o_mode_unsupported,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [2:0]            i_cfg_index,
    input  wire logic [15:0]           i_cfg_data
);
    import wck_pkg::*;

    localparam int PIPE_D = 6 + DIV_W;

    // Configuration registers.
    logic [2:0]  r_mode;
    logic [15:0] r_radius;
    logic [15:0] r_spacing;
    logic [14:0] r_lim_lin;
    logic [14:0] r_lim_ang;

    // Valid and unsupported-mode flags that travel alongside the data.
    logic        r_vld [PIPE_D];
    logic        r_uns [PIPE_D];

    logic        en;
    logic        n_uns;
    t_lane_cmd   cmd_a, cmd_b, cmd_c;
    logic [DIV_W-1:0] dvd_a, dvd_b, dvd_c;
    logic [15:0] dsr_a, dsr_b, dsr_c;
    t_side       sd_a, sd_b, sd_c;
    logic [DIV_W-1:0] q_a, q_b, q_c;
    t_side       qs_a, qs_b, qs_c;
    logic signed [31:0] n_out_a, n_out_b, n_out_c;

    assign en          = !o_out_valid || i_out_ready;
    assign o_in_ready  = en;
    assign o_cfg_ready = 1'b1;
    assign n_uns       = (r_mode != MODE_CODE_DIFF) && (r_mode != MODE_CODE_OMNI);

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= RST_MODE;
            r_radius  <= RST_RADIUS;
            r_spacing <= RST_SPACING;
            r_lim_lin <= RST_LIM_LIN;
            r_lim_ang <= RST_LIM_ANG;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_MODE:    r_mode    <= i_cfg_data[2:0];
                REG_RADIUS:  r_radius  <= i_cfg_data;
                REG_SPACING: r_spacing <= i_cfg_data;
                REG_LIM_LIN: r_lim_lin <= i_cfg_data[14:0];
                REG_LIM_ANG: r_lim_ang <= i_cfg_data[14:0];
                default: begin
                end
            endcase
        end
    end

    // Valid and flag delay line.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PIPE_D; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_in_valid;
            for (int k = 1; k < PIPE_D; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_uns[0] <= n_uns;
            for (int k = 1; k < PIPE_D; k++) begin
                r_uns[k] <= r_uns[k-1];
            end
        end
    end

    wck_front u_front (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_action  (i_action),
        .i_lin_x   (i_lin_x),
        .i_lin_y   (i_lin_y),
        .i_ang_z   (i_ang_z),
        .i_wheel_a (i_wheel_a),
        .i_wheel_b (i_wheel_b),
        .i_wheel_c (i_wheel_c),
        .i_mode    (r_mode),
        .i_radius  (r_radius),
        .i_spacing (r_spacing),
        .i_lim_lin (r_lim_lin),
        .i_lim_ang (r_lim_ang),
        .o_cmd_a   (cmd_a),
        .o_cmd_b   (cmd_b),
        .o_cmd_c   (cmd_c)
    );

    wck_scale u_scale_a (
        .i_clk(i_clk), .i_en(en), .i_cmd(cmd_a),
        .o_dividend(dvd_a), .o_d(dsr_a), .o_side(sd_a)
    );
    wck_scale u_scale_b (
        .i_clk(i_clk), .i_en(en), .i_cmd(cmd_b),
        .o_dividend(dvd_b), .o_d(dsr_b), .o_side(sd_b)
    );
    wck_scale u_scale_c (
        .i_clk(i_clk), .i_en(en), .i_cmd(cmd_c),
        .o_dividend(dvd_c), .o_d(dsr_c), .o_side(sd_c)
    );

    wck_div #(.DIV_W(DIV_W)) u_div_a (
        .i_clk(i_clk), .i_en(en), .i_dividend(dvd_a), .i_d(dsr_a), .i_side(sd_a),
        .o_q(q_a), .o_side(qs_a)
    );
    wck_div #(.DIV_W(DIV_W)) u_div_b (
        .i_clk(i_clk), .i_en(en), .i_dividend(dvd_b), .i_d(dsr_b), .i_side(sd_b),
        .o_q(q_b), .o_side(qs_b)
    );
    wck_div #(.DIV_W(DIV_W)) u_div_c (
        .i_clk(i_clk), .i_en(en), .i_dividend(dvd_c), .i_d(dsr_c), .i_side(sd_c),
        .o_q(q_c), .o_side(qs_c)
    );

    // Final signed saturation of quotients, or the bypass value.
    function automatic logic signed [31:0] fin(input logic [DIV_W-1:0] q, input t_side sd);
        logic signed [31:0] res;
        res = sd.byp;
        if (sd.use_div) begin
            if (q[DIV_W-1:31] != '0) begin
                res = sd.neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
            end else begin
                res = sd.neg ? -$signed({1'b0, q[30:0]}) : $signed({1'b0, q[30:0]});
            end
        end
        return res;
    endfunction

    assign n_out_a = fin(q_a, qs_a);
    assign n_out_b = fin(q_b, qs_b);
    assign n_out_c = fin(q_c, qs_c);

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (en) begin
            o_out_valid <= r_vld[PIPE_D-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_out_a            <= n_out_a;
            o_out_b            <= n_out_b;
            o_out_c            <= n_out_c;
            o_mode_unsupported <= r_uns[PIPE_D-1];
        end
    end

    // An unsupported mode always reports all-zero results.
    a_uns_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_mode_unsupported) |->
            (o_out_a == 32'sd0 && o_out_b == 32'sd0 && o_out_c == 32'sd0))
        else $error("unsupported mode gave a nonzero result");

    // A result only appears when the last pipeline stage held a valid item.
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_vld[PIPE_D-1]))
        else $error("output valid rose without an item in the pipeline");

    // A stall freezes the output register; the check covers results a and c.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> $stable(o_out_a) && $stable(o_out_c))
        else $error("result changed during a stall");

endmodule

`default_nettype wire

// ===== dv/wheel_chassis_kinematics_test.sv =====
// Self-checking testbench for wheel_chassis_kinematics: a directed table, then random phases.
// Depends on wck_pkg and the RTL of the block; expected results come from the directed table or a built-in predictor.
`default_nettype none

module wheel_chassis_kinematics_test;
    import wck_pkg::*;

    // Operation codes of the action field.
    localparam logic ACT_INV = 1'b0;
    localparam logic ACT_FWD = 1'b1;

    // Mode codes outside the two supported chassis.
    localparam logic [2:0] MODE_CODE_OFF0 = 3'd0;
    localparam logic [2:0] MODE_CODE_OFF1 = 3'd1;
    localparam logic [2:0] MODE_CODE_OFF4 = 3'd4;
    localparam logic [2:0] MODE_CODE_OFF7 = 3'd7;

    localparam int  DRAIN_CYCLES = 60;
    localparam int  CYCLE_LIMIT  = 400000;
    localparam int  PHASES       = 8;
    localparam int  PHASE_ITEMS  = 85;

    typedef struct {
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic               unsup;
    } t_wheel_res;

    typedef struct {
        logic [2:0]         mode;
        logic               act;
        logic signed [15:0] lx;
        logic signed [15:0] ly;
        logic signed [15:0] az;
        logic signed [23:0] wa;
        logic signed [23:0] wb;
        logic signed [23:0] wc;
        bit                 typed;
        int                 ea;
        int                 eb;
        int                 ec;
        bit                 eu;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic               i_action = ACT_INV;
    logic signed [15:0] i_lin_x = '0;
    logic signed [15:0] i_lin_y = '0;
    logic signed [15:0] i_ang_z = '0;
    logic signed [23:0] i_wheel_a = '0;
    logic signed [23:0] i_wheel_b = '0;
    logic signed [23:0] i_wheel_c = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [31:0] o_out_a;
    logic signed [31:0] o_out_b;
    logic signed [31:0] o_out_c;
    logic               o_mode_unsupported;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = REG_MODE;
    logic [15:0]        i_cfg_data = '0;

    // Shadow copy of the configuration registers.
    logic [2:0]  cur_mode    = RST_MODE;
    longint      cur_radius  = RST_RADIUS;
    longint      cur_spacing = RST_SPACING;
    longint      cur_lim_lin = RST_LIM_LIN;
    longint      cur_lim_ang = RST_LIM_ANG;

    t_wheel_res  pending_res[$];
    int          err_count = 0;
    int          cycle_count = 0;
    bit          burst = 1'b0;
    int          out_stall = 0;

    wheel_chassis_kinematics dut (.*);

    always #4 i_clk = ~i_clk;

    // Rounded division, ties away from zero.
    function automatic longint round_div(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic int sat32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return int'(v);
    endfunction

    function automatic longint clamp_cmd(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // Expected wheel speeds or body velocity for one command.
    function automatic t_wheel_res kinematics(logic act, logic signed [15:0] lx,
            logic signed [15:0] ly, logic signed [15:0] az, logic signed [23:0] wa,
            logic signed [23:0] wb, logic signed [23:0] wc);
        t_wheel_res res;
        longint ra, rb, rc, r, s, x, y, w, a, b, c, h, xs, yh, sw, den;
        ra = 0; rb = 0; rc = 0;
        res.unsup = 1'b0;
        r = (cur_radius == 0) ? 1 : cur_radius;
        s = (cur_spacing == 0) ? 1 : cur_spacing;
        if (act == ACT_INV) begin
            x = clamp_cmd(longint'(lx), cur_lim_lin);
            y = longint'(ly);
            w = clamp_cmd(longint'(az), cur_lim_ang);
            if (cur_mode == MODE_CODE_DIFF) begin
                h = round_div(w * s, 64'sd1 << 17);
                ra = x - h;
                rb = -(x + h);
            end else if (cur_mode == MODE_CODE_OMNI) begin
                den = r << 16;
                xs = x * longint'(SIN60_Q16);
                yh = y * 32768;
                sw = s * w;
                ra = round_div((xs + yh + sw) * longint'(K30PI_Q16), den);
                rb = round_div(-(xs - yh - sw) * longint'(K30PI_Q16), den);
                rc = round_div((-(y * 65536) + sw) * longint'(K30PI_Q16), den);
            end else begin
                res.unsup = 1'b1;
            end
        end else begin
            a = longint'(wa);
            b = longint'(wb);
            c = longint'(wc);
            if (cur_mode == MODE_CODE_DIFF) begin
                ra = b - a;
                rb = a + b;
            end else if (cur_mode == MODE_CODE_OMNI) begin
                ra = round_div((a - b) * r * longint'(C_VX_Q24), 64'sd1 << 40);
                rb = round_div((a + b - 2 * c) * r * longint'(C_PI90_Q24), 64'sd1 << 40);
                rc = round_div((a + b + c) * r * longint'(C_PI90_Q24), s << 24);
            end else begin
                res.unsup = 1'b1;
            end
        end
        res.a = sat32(ra);
        res.b = sat32(rb);
        res.c = sat32(rc);
        return res;
    endfunction

    // Drive one command after a random gap, none during bursts, and record its expectation on transfer.
    task automatic send_cmd(t_row row);
        int gap;
        t_wheel_res res;
        gap = burst ? 0 : $urandom_range(15);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_action  <= row.act;
        i_lin_x   <= row.lx;
        i_lin_y   <= row.ly;
        i_ang_z   <= row.az;
        i_wheel_a <= row.wa;
        i_wheel_b <= row.wb;
        i_wheel_c <= row.wc;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        if (row.typed) begin
            res.a = row.ea; res.b = row.eb; res.c = row.ec; res.unsup = row.eu;
        end else begin
            res = kinematics(row.act, row.lx, row.ly, row.az, row.wa, row.wb, row.wc);
        end
        pending_res.push_back(res);
    endtask

    // Hold off the sender until every result is back and the pipeline is empty.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One register write; valid drops for a cycle before the next write starts.
    task automatic write_reg(t_reg_idx idx, logic [15:0] data);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_MODE:    cur_mode    = data[2:0];
            REG_RADIUS:  cur_radius  = data;
            REG_SPACING: cur_spacing = data;
            REG_LIM_LIN: cur_lim_lin = data[14:0];
            REG_LIM_ANG: cur_lim_ang = data[14:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random values leaning toward the extremes now and then.
    function automatic logic [15:0] pick16();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return $urandom_range(1) ? 16'h0000 : 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [23:0] pick24();
        case ($urandom_range(7))
            0: return 24'h800000;
            1: return 24'h7fffff;
            2: return $urandom_range(1) ? 24'h000000 : 24'hffffff;
            default: return 24'($urandom);
        endcase
    endfunction

    // Directed commands, grouped by chassis mode.
    t_row dir_rows[] = '{
        '{MODE_CODE_DIFF, ACT_INV, 16'sd0, 16'sd0, 16'sd0, 0, 0, 0, 1, 0, 0, 0, 0},
        '{MODE_CODE_DIFF, ACT_INV, 16'sh7fff, 16'sd0, 16'sd0, 0, 0, 0, 1, 2048, -2048, 0, 0},
        '{MODE_CODE_DIFF, ACT_INV, 16'sh8000, 16'sd0, 16'sd0, 0, 0, 0, 1, -2048, 2048, 0, 0},
        '{MODE_CODE_DIFF, ACT_INV, 16'sd0, 16'sh7fff, 16'sh7fff, 0, 0, 0, 0, 0, 0, 0, 0},
        '{MODE_CODE_DIFF, ACT_INV, 16'sd1000, 16'sh8000, 16'sh8000, 0, 0, 0, 0, 0, 0, 0, 0},
        '{MODE_CODE_DIFF, ACT_FWD, 16'sd5, 16'sd5, 16'sd5, 24'sd100, 24'sd300, 24'sd7,
          1, 200, 400, 0, 0},
        '{MODE_CODE_DIFF, ACT_FWD, 0, 0, 0, 24'sh800000, 24'sh7fffff, 24'sh7fffff,
          1, 16777215, -1, 0, 0},
        '{MODE_CODE_DIFF, ACT_FWD, 0, 0, 0, 24'sh800000, 24'sh800000, 24'sh800000,
          1, 0, -16777216, 0, 0},
        '{MODE_CODE_OMNI, ACT_INV, 16'sd0, 16'sd0, 16'sd0, 0, 0, 0, 1, 0, 0, 0, 0},
        '{MODE_CODE_OMNI, ACT_INV, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0, 0, 0, 0, 0, 0, 0, 0},
        '{MODE_CODE_OMNI, ACT_INV, 16'sh8000, 16'sh8000, 16'sh8000, 0, 0, 0, 0, 0, 0, 0, 0},
        '{MODE_CODE_OMNI, ACT_INV, 16'sd300, 16'sd0, 16'sd0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{MODE_CODE_OMNI, ACT_FWD, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0},
        '{MODE_CODE_OMNI, ACT_FWD, 0, 0, 0, 24'sh7fffff, 24'sh800000, 24'sh800000,
          0, 0, 0, 0, 0},
        '{MODE_CODE_OMNI, ACT_FWD, 0, 0, 0, 24'sh800000, 24'sh800000, 24'sh800000,
          0, 0, 0, 0, 0},
        '{MODE_CODE_OMNI, ACT_FWD, 0, 0, 0, 24'sd4096, 24'sd4096, 24'sd4096, 0, 0, 0, 0, 0},
        '{MODE_CODE_OFF0, ACT_INV, 16'sh7fff, 16'sd9, 16'sd9, 0, 0, 0, 1, 0, 0, 0, 1},
        '{MODE_CODE_OFF1, ACT_FWD, 0, 0, 0, 24'sd5, 24'sd6, 24'sd7, 1, 0, 0, 0, 1},
        '{MODE_CODE_OFF4, ACT_INV, 16'sd1, 16'sd2, 16'sd3, 0, 0, 0, 1, 0, 0, 0, 1},
        '{MODE_CODE_OFF7, ACT_FWD, 0, 0, 0, 24'sh7fffff, 24'sh800000, 24'sd1, 1, 0, 0, 0, 1}
    };

    // Result side: random stall before each transfer, none during bursts.
    always @(posedge i_clk) begin
        bit rdy_next;
        if (!i_rst_n) begin
            rdy_next = 1'b0;
            out_stall = 0;
        end else if (o_out_valid && i_out_ready) begin
            out_stall = burst ? 0 : $urandom_range(15);
            rdy_next = (out_stall == 0);
        end else if (out_stall > 0) begin
            out_stall = out_stall - 1;
            rdy_next = (out_stall == 0);
        end else begin
            rdy_next = 1'b1;
        end
        i_out_ready <= rdy_next;
    end

    // Compare each result transfer with the oldest expectation.
    always @(posedge i_clk) begin
        t_wheel_res want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_res.size() == 0) begin
                $error("result with no command outstanding");
                err_count++;
            end else begin
                want = pending_res.pop_front();
                if (o_out_a !== want.a) begin
                    $error("out_a: expected %0d, got %0d", want.a, o_out_a);
                    err_count++;
                end
                if (o_out_b !== want.b) begin
                    $error("out_b: expected %0d, got %0d", want.b, o_out_b);
                    err_count++;
                end
                if (o_out_c !== want.c) begin
                    $error("out_c: expected %0d, got %0d", want.c, o_out_c);
                    err_count++;
                end
                if (o_mode_unsupported !== want.unsup) begin
                    $error("mode_unsupported: expected %0b, got %0b", want.unsup,
                           o_mode_unsupported);
                    err_count++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Stimulus sequence.
    initial begin
        t_row row;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            if (dir_rows[k].mode != cur_mode) begin
                drain();
                write_reg(REG_MODE, {13'd0, dir_rows[k].mode});
            end
            send_cmd(dir_rows[k]);
        end

        for (int p = 0; p < PHASES; p++) begin
            drain();
            // Extreme settings first, then random ones.
            case (p)
                0: begin
                    write_reg(REG_MODE, {13'd0, MODE_CODE_OMNI});
                    write_reg(REG_RADIUS, 16'hffff);
                    write_reg(REG_SPACING, 16'hffff);
                    write_reg(REG_LIM_LIN, 16'h7fff);
                    write_reg(REG_LIM_ANG, 16'h7fff);
                end
                1: begin
                    write_reg(REG_MODE, {13'd0, MODE_CODE_OMNI});
                    write_reg(REG_RADIUS, 16'h0000);
                    write_reg(REG_SPACING, 16'h0000);
                    write_reg(REG_LIM_LIN, 16'h0000);
                    write_reg(REG_LIM_ANG, 16'h0000);
                end
                2: begin
                    write_reg(REG_MODE, {13'd0, MODE_CODE_DIFF});
                    write_reg(REG_RADIUS, 16'h0001);
                    write_reg(REG_SPACING, 16'hffff);
                    write_reg(REG_LIM_LIN, 16'hffff);
                    write_reg(REG_LIM_ANG, 16'h7fff);
                end
                default: begin
                    write_reg(REG_MODE, (p % 3 == 0) ? 16'($urandom_range(7))
                                      : {13'd0, (p % 2) ? MODE_CODE_OMNI : MODE_CODE_DIFF});
                    write_reg(REG_RADIUS, 16'($urandom));
                    write_reg(REG_SPACING, 16'($urandom));
                    write_reg(REG_LIM_LIN, 16'($urandom));
                    write_reg(REG_LIM_ANG, 16'($urandom));
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Pick stretches with or without idle cycles at random.
                if (n % 20 == 0) burst = ($urandom_range(3) == 0);
                row.mode  = cur_mode;
                row.act   = 1'($urandom_range(1));
                row.lx    = pick16();
                row.ly    = pick16();
                row.az    = pick16();
                row.wa    = pick24();
                row.wb    = pick24();
                row.wc    = pick24();
                row.typed = 1'b0;
                send_cmd(row);
            end
            burst = 1'b0;
        end

        drain();
        if (err_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
hw/rtl/wck_pkg.sv
hw/rtl/wck_front.sv
hw/rtl/wck_scale.sv
hw/rtl/wck_div.sv
hw/rtl/wheel_chassis_kinematics.sv
dv/wheel_chassis_kinematics_test.sv
